@@ rtl/rpn_pkg.sv @@
// Package with opcode and error codes and widths for the postfix stack machine.
`default_nettype none
package rpn_pkg;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int VAR_COUNT_DEF   = 256;
   localparam int DATA_W = 32;

   localparam logic [5:0] OP_FALSE = 6'd8;
   localparam logic [5:0] OP_TRUE  = 6'd17;
   localparam logic [5:0] OP_LIT   = 6'd40;
   localparam logic [5:0] OP_LOAD  = 6'd41;
   localparam logic [5:0] OP_LABEL = 6'd42;
   localparam logic [5:0] OP_ADDR  = 6'd43;
   localparam logic [5:0] OP_NOT   = 6'd11;
   localparam logic [5:0] OP_AND   = 6'd1;
   localparam logic [5:0] OP_OR    = 6'd12;
   localparam logic [5:0] OP_ADD   = 6'd33;
   localparam logic [5:0] OP_SUB   = 6'd34;
   localparam logic [5:0] OP_MUL   = 6'd35;
   localparam logic [5:0] OP_DIV   = 6'd36;
   localparam logic [5:0] OP_EQ    = 6'd30;
   localparam logic [5:0] OP_LT    = 6'd31;
   localparam logic [5:0] OP_GT    = 6'd32;
   localparam logic [5:0] OP_LE    = 6'd37;
   localparam logic [5:0] OP_NE    = 6'd38;
   localparam logic [5:0] OP_GE    = 6'd39;
   localparam logic [5:0] OP_ASSIGN = 6'd27;
   localparam logic [5:0] OP_READ  = 6'd14;
   localparam logic [5:0] OP_WRITE = 6'd20;
   localparam logic [5:0] OP_JMP   = 6'd44;
   localparam logic [5:0] OP_JMPF  = 6'd45;
   localparam logic [5:0] OP_DUP   = 6'd46;
   localparam logic [5:0] OP_POP   = 6'd47;

   localparam logic [2:0] ERR_OK         = 3'd0;
   localparam logic [2:0] ERR_UNASSIGNED = 3'd1;
   localparam logic [2:0] ERR_DIVZERO    = 3'd2;
   localparam logic [2:0] ERR_UNKNOWN    = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW   = 3'd4;
   localparam logic [2:0] ERR_UNDERFLOW  = 3'd5;

   typedef struct packed {
      logic       known;
      logic [1:0] pops;
      logic [1:0] pushes;
   } effect_type;

   function automatic effect_type stack_effect(input logic [5:0] op);
      effect_type e;
      e = '{known: 1'b1, pops: 2'd0, pushes: 2'd0};
      unique case (op)
         OP_FALSE, OP_TRUE, OP_LIT, OP_LABEL, OP_ADDR, OP_LOAD: e.pushes = 2'd1;
         OP_NOT: begin e.pops = 2'd1; e.pushes = 2'd1; end
         OP_DUP: begin e.pops = 2'd1; e.pushes = 2'd2; end
         OP_AND, OP_OR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
         OP_EQ, OP_LT, OP_GT, OP_LE, OP_NE, OP_GE: begin
            e.pops = 2'd2; e.pushes = 2'd1;
         end
         OP_ASSIGN, OP_JMPF: e.pops = 2'd2;
         OP_READ, OP_WRITE, OP_JMP, OP_POP: e.pops = 2'd1;
         default: e.known = 1'b0;
      endcase
      return e;
   endfunction
endpackage
`default_nettype wire

@@ rtl/rpn_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/rpn_divider.sv @@
// Iterative restoring divider, signed truncating, one quotient bit per cycle.
`default_nettype none
module rpn_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic      [31:0] quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in;
   logic [32:0] trial;

   assign trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
   assign done = busy_ff && (cnt_ff == 6'd0);
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         rem_in  = '0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         den_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 6'd1;
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; neg_ff <= neg_in;
   end
endmodule
`default_nettype wire

@@ rtl/rpn_stack_machine_executer.sv @@
// Top level of the postfix stack machine executer.
// The req_ channel takes one instruction word: opcode, operand and read value.
// The rsp_ channel returns one result word per instruction: jump flag and
// target, write flag and value, and an error code.
// An instruction is taken when req_tvalid and req_tready are both high. The
// block then reads the top two stack entries from the stack memory, one entry
// a cycle, and the variable memory, each with registered read data.
// Most instructions pass through S_RD1, S_RD2 and S_EXEC before the result word
// is shown in S_RSP; multiply adds S_MUL; divide waits in S_DIV for the divider.
// After the result word is shown, req_tready rises again once it is taken, so
// the block takes no new instruction before the last result word is taken.
// Reset empties the stack and clears the assigned flags, which are held in
// flip-flops; stack and variable values are undefined until written.
// While rsp_tready is low the result word is held and no instruction is taken.
// An instruction that reports an error changes no state.
`default_nettype none
module rpn_stack_machine_executer #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
   parameter int VAR_COUNT   = rpn_pkg::VAR_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // opcode[5:0], operand[37:6], read_value[69:38], zeros up to 71
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // jump_taken[0], jump_target[32:1], write_valid[33], write_value[65:34],
   // error_code[68:66], zeros up to 71
   output logic      [71:0] rsp_tdata
);
   import rpn_pkg::*;

   localparam int SA = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int VA = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD1  = 3'd1;
   localparam logic [2:0] S_RD2  = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_RSP  = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [5:0]  op_ff;
   logic [31:0] opnd_ff, rdv_ff, a_ff, b_ff, a_in, b_in, prod_ff;
   logic [VAR_COUNT-1:0] asg_ff, asg_in;
   logic [71:0] rsp_ff, rsp_in;
   effect_type  eff;

   logic        st_we;
   logic [SA-1:0] st_wa, st_ra;
   logic [31:0] st_wd, st_rd;
   logic        var_we;
   logic [VA-1:0] var_wa;
   logic [31:0] var_wd, var_rd;

   logic        div_start, div_done;
   logic [31:0] div_q;

   logic [2:0]  err;
   logic [31:0] r;
   logic        jt, wv;
   logic [31:0] jtg, wval;
   logic        do_push;
   logic [31:0] vidx;
   logic        vidx_ok;
   logic [SPW-1:0] sp_after;
   logic        dup_pend_ff, dup_pend_in;

   assign eff = stack_effect(op_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RSP);
   assign rsp_tdata  = rsp_ff;

   rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));

   rpn_ram #(.WIDTH(32), .DEPTH(VAR_COUNT)) u_vars (
      .clock(clock), .wr_en(var_we), .wr_addr(var_wa), .wr_data(var_wd),
      .rd_addr(opnd_ff[VA-1:0]), .rd_data(var_rd));

   rpn_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(b_in),
      .divisor(a_ff), .done(div_done), .quotient(div_q));

   always_comb begin
      st_ra = '0;
      if (state_ff == S_IDLE) st_ra = SA'(sp_ff - SPW'(1));
      else st_ra = SA'(sp_ff - SPW'(2));
   end

   always_comb begin
      err = ERR_OK; r = '0; jt = 1'b0; wv = 1'b0; jtg = '0; wval = '0;
      do_push = 1'b0; vidx = '0;
      if (!eff.known) err = ERR_UNKNOWN;
      else if ({1'b0, sp_ff} < (SPW+1)'(eff.pops)) err = ERR_UNDERFLOW;
      else if ((SPW+2)'(sp_ff) - (SPW+2)'(eff.pops) + (SPW+2)'(eff.pushes)
               > (SPW+2)'(STACK_DEPTH))
         err = ERR_OVERFLOW;
      if (op_ff == OP_ASSIGN) vidx = b_ff;
      else if (op_ff == OP_READ) vidx = a_ff;
      else vidx = opnd_ff;
      vidx_ok = (vidx < 32'(VAR_COUNT)) && asg_ff[VA'(vidx)];
      if (err == ERR_OK) begin
         unique case (op_ff)
            OP_FALSE: r = 32'd0;
            OP_TRUE:  r = 32'd1;
            OP_LIT, OP_LABEL, OP_ADDR: r = opnd_ff;
            OP_LOAD: if (!vidx_ok) err = ERR_UNASSIGNED; else r = var_rd;
            OP_NOT: r = {31'd0, a_ff == 32'd0};
            OP_AND: r = {31'd0, (a_ff != 32'd0) && (b_ff != 32'd0)};
            OP_OR:  r = {31'd0, (a_ff != 32'd0) || (b_ff != 32'd0)};
            OP_ADD: r = b_ff + a_ff;
            OP_SUB: r = b_ff - a_ff;
            OP_MUL: r = prod_ff;
            OP_DIV: if (a_ff == 32'd0) err = ERR_DIVZERO; else r = div_q;
            OP_EQ: r = {31'd0, b_ff == a_ff};
            OP_LT: r = {31'd0, $signed(b_ff) < $signed(a_ff)};
            OP_GT: r = {31'd0, $signed(a_ff) < $signed(b_ff)};
            OP_LE: r = {31'd0, !($signed(a_ff) < $signed(b_ff))};
            OP_NE: r = {31'd0, b_ff != a_ff};
            OP_GE: r = {31'd0, !($signed(b_ff) < $signed(a_ff))};
            OP_ASSIGN, OP_READ: if (vidx >= 32'(VAR_COUNT)) err = ERR_UNASSIGNED;
            OP_WRITE: begin wv = 1'b1; wval = a_ff; end
            OP_JMP: begin jt = 1'b1; jtg = a_ff; end
            OP_JMPF: if (b_ff == 32'd0) begin jt = 1'b1; jtg = a_ff; end
            OP_DUP: r = a_ff;
            default: r = '0;
         endcase
      end
      if (err != ERR_OK) begin jt = 1'b0; jtg = '0; wv = 1'b0; wval = '0; end
      do_push = (err == ERR_OK) && (eff.pushes != 2'd0);
      sp_after = sp_ff - SPW'(eff.pops) + SPW'(eff.pushes);
   end

   always_comb begin
      state_in = state_ff; sp_in = sp_ff; a_in = a_ff; b_in = b_ff;
      asg_in = asg_ff; rsp_in = rsp_ff;
      st_we = 1'b0; st_wa = '0; st_wd = r;
      var_we = 1'b0; var_wa = VA'(vidx); var_wd = '0; div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_RD1;
         S_RD1: begin a_in = st_rd; state_in = S_RD2; end
         S_RD2: begin
            b_in = st_rd;
            state_in = S_EXEC;
            if (op_ff == OP_MUL) state_in = S_MUL;
            else if (op_ff == OP_DIV && a_ff != 32'd0 && eff.known
                     && sp_ff >= SPW'(2)) begin
               state_in = S_DIV; div_start = 1'b1;
            end
         end
         S_MUL: state_in = S_EXEC;
         S_DIV: if (div_done) state_in = S_EXEC;
         S_EXEC: begin
            rsp_in = {3'd0, err, wval, wv, jtg, jt};
            if (err == ERR_OK) begin
               sp_in = sp_after;
               if (do_push) begin
                  st_we = 1'b1;
                  st_wa = SA'(sp_ff - SPW'(eff.pops));
               end
               if (op_ff == OP_ASSIGN || op_ff == OP_READ) begin
                  var_we = 1'b1;
                  var_wd = (op_ff == OP_ASSIGN) ? a_ff : rdv_ff;
                  asg_in[VA'(vidx)] = 1'b1;
               end
               if (op_ff == OP_DUP) begin
                  state_in = S_RSP;
               end
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_RSP && dup_pend_ff) begin
         st_we = 1'b1; st_wa = SA'(sp_ff - SPW'(1)); st_wd = a_ff;
      end
   end

   always_comb begin
      dup_pend_in = 1'b0;
      if (state_ff == S_EXEC) dup_pend_in = (op_ff == OP_DUP) && (err == ERR_OK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
         asg_ff   <= '0;
         dup_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         asg_ff   <= asg_in;
         dup_pend_ff <= dup_pend_in;
      end
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tdata[5:0];
         opnd_ff <= req_tdata[37:6];
         rdv_ff  <= req_tdata[69:38];
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= b_ff * a_ff;
      rsp_ff  <= rsp_in;
   end

   ap_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH)) else $error("stack pointer past depth");
   ap_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request and response both open");
   ap_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[68:66] != ERR_OK |-> rsp_tdata[65:0] == '0)
      else $error("error word carries payload");
endmodule
`default_nettype wire

@@ sim/rpn_stack_machine_executer_test.sv @@
// Self-checking testbench for the postfix stack machine executer, with directed and random instruction streams.
`timescale 1ns / 1ps
module rpn_stack_machine_executer_test;
   import rpn_pkg::*;

   localparam int DEPTH = 64;
   localparam int NVARS = 256;
   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;

   rpn_stack_machine_executer u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   logic [71:0] instr_queue[$];
   logic [71:0] result_queue[$];
   logic [31:0] stack_mem[DEPTH];
   logic [31:0] var_mem[NVARS];
   bit          var_set[NVARS];
   int          depth_now;
   int          fail_count;
   int          cycle_count;
   int          send_idle;
   int          recv_stall;
   int          gen_depth;
   int          hold_left;
   bit          hold_armed;
   bit          hold_taken;
   bit          word_taken;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit op_shape(input logic [5:0] op, output int pops, output int pushes);
      pops = 0;
      pushes = 0;
      case (op)
         OP_FALSE, OP_TRUE, OP_LIT, OP_LABEL, OP_ADDR, OP_LOAD: pushes = 1;
         OP_NOT: begin pops = 1; pushes = 1; end
         OP_DUP: begin pops = 1; pushes = 2; end
         OP_AND, OP_OR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
         OP_EQ, OP_LT, OP_GT, OP_LE, OP_NE, OP_GE: begin pops = 2; pushes = 1; end
         OP_ASSIGN, OP_JMPF: pops = 2;
         OP_READ, OP_WRITE, OP_JMP, OP_POP: pops = 1;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   task automatic execute_instr(input logic [5:0] op, input logic [31:0] opnd,
                                input logic [31:0] rd, output logic [71:0] word);
      int          pops;
      int          pushes;
      logic [2:0]  err;
      logic        jt;
      logic        wv;
      logic [31:0] jtarget;
      logic [31:0] wval;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r;
      err = ERR_OK;
      jt = 0; wv = 0; jtarget = 0; wval = 0; a = 0; b = 0; r = 0;
      if (!op_shape(op, pops, pushes)) err = ERR_UNKNOWN;
      else if (depth_now < pops) err = ERR_UNDERFLOW;
      else if (depth_now - pops + pushes > DEPTH) err = ERR_OVERFLOW;
      else begin
         if (pops >= 1) a = stack_mem[depth_now - 1];
         if (pops >= 2) b = stack_mem[depth_now - 2];
         case (op)
            OP_FALSE: r = 0;
            OP_TRUE:  r = 1;
            OP_LIT, OP_LABEL, OP_ADDR: r = opnd;
            OP_LOAD: begin
               if (opnd >= NVARS || !var_set[opnd]) err = ERR_UNASSIGNED;
               else r = var_mem[opnd];
            end
            OP_NOT: r = (a == 0);
            OP_AND: r = (a != 0 && b != 0);
            OP_OR:  r = (a != 0 || b != 0);
            OP_ADD: r = b + a;
            OP_SUB: r = b - a;
            OP_MUL: r = b * a;
            OP_DIV: begin
               if (a == 0) err = ERR_DIVZERO;
               else if (b == 32'h8000_0000 && a == 32'hFFFF_FFFF) r = b;
               else r = $signed(b) / $signed(a);
            end
            OP_EQ: r = (b == a);
            OP_LT: r = ($signed(b) < $signed(a));
            OP_GT: r = ($signed(b) > $signed(a));
            OP_LE: r = ($signed(b) <= $signed(a));
            OP_NE: r = (b != a);
            OP_GE: r = ($signed(b) >= $signed(a));
            OP_ASSIGN: begin
               if (b >= NVARS) err = ERR_UNASSIGNED;
               else begin var_mem[b] = a; var_set[b] = 1; end
            end
            OP_READ: begin
               if (a >= NVARS) err = ERR_UNASSIGNED;
               else begin var_mem[a] = rd; var_set[a] = 1; end
            end
            OP_WRITE: begin wv = 1; wval = a; end
            OP_JMP: begin jt = 1; jtarget = a; end
            OP_JMPF: if (b == 0) begin jt = 1; jtarget = a; end
            OP_DUP: r = a;
            default: ;
         endcase
         if (err == ERR_OK) begin
            depth_now = depth_now - pops;
            repeat (pushes) begin
               stack_mem[depth_now] = r;
               depth_now++;
            end
         end
      end
      if (err != ERR_OK) begin jt = 0; jtarget = 0; wv = 0; wval = 0; end
      word = {3'b000, err, wval, wv, jtarget, jt};
   endtask

   task automatic add_instr(input logic [5:0] op, input logic [31:0] opnd = 0,
                            input logic [31:0] rd = 0);
      int pops;
      int pushes;
      instr_queue.insert(instr_queue.size(), {2'b00, rd, opnd, op});
      if (op_shape(op, pops, pushes) && gen_depth >= pops && gen_depth - pops + pushes <= DEPTH)
         gen_depth = gen_depth - pops + pushes;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(20)) - 32'd10;
         2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom_range(5);
      endcase
   endfunction

   function automatic logic [31:0] rand_index();
      return ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(7));
   endfunction

   task automatic push_operand();
      case ($urandom_range(5))
         0: add_instr(OP_LOAD, rand_index(), $urandom);
         1: add_instr(OP_TRUE, $urandom, $urandom);
         2: add_instr(OP_FALSE, $urandom, $urandom);
         default: add_instr(OP_LIT, rand_value(), $urandom);
      endcase
   endtask

   task automatic random_items(input int count);
      logic [5:0] binops[12];
      int         start;
      binops = '{OP_AND, OP_OR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                 OP_EQ, OP_LT, OP_GT, OP_LE, OP_NE, OP_GE};
      start = instr_queue.size();
      while (instr_queue.size() - start < count) begin
         case ($urandom_range(99)) inside
            [0:44]: begin
               while (gen_depth < 2) push_operand();
               if (gen_depth > 40) add_instr(OP_POP);
               else if (gen_depth < DEPTH) push_operand();
               add_instr(binops[$urandom_range(11)], $urandom, $urandom);
            end
            [45:54]: begin
               add_instr(OP_ADDR, rand_index(), $urandom);
               push_operand();
               add_instr(OP_ASSIGN, $urandom, $urandom);
            end
            [55:62]: begin
               add_instr(OP_ADDR, rand_index(), $urandom);
               add_instr(OP_READ, $urandom, $urandom);
            end
            [63:72]: begin
               if (gen_depth == 0) push_operand();
               add_instr(OP_WRITE, $urandom, $urandom);
            end
            [73:80]: begin
               if ($urandom_range(1)) begin
                  push_operand();
                  add_instr(OP_LABEL, $urandom, $urandom);
                  add_instr(OP_JMPF, $urandom, $urandom);
               end else begin
                  add_instr(OP_LABEL, $urandom, $urandom);
                  add_instr(OP_JMP, $urandom, $urandom);
               end
            end
            [81:86]: begin
               if (gen_depth == 0) push_operand();
               add_instr($urandom_range(1) ? OP_DUP : OP_NOT, $urandom, $urandom);
            end
            [87:88]: begin
               while (gen_depth < DEPTH) push_operand();
               add_instr(OP_LIT, $urandom, $urandom);
               add_instr(OP_DUP, $urandom, $urandom);
               repeat ($urandom_range(DEPTH, 50)) add_instr(OP_POP, $urandom, $urandom);
            end
            default: add_instr(6'($urandom), $urandom, $urandom);
         endcase
      end
   endtask

   task automatic wait_drained();
      while (instr_queue.size() != 0 || req_tvalid || result_queue.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      logic [71:0] want;
      logic [71:0] prediction;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      word_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_queue.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = result_queue.pop_front();
            if (rsp_tdata[0] !== want[0]) begin
               $error("jump_taken expected %0d got %0d", want[0], rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[32:1] !== want[32:1]) begin
               $error("jump_target expected %h got %h", want[32:1], rsp_tdata[32:1]);
               fail_count++;
            end
            if (rsp_tdata[33] !== want[33]) begin
               $error("write_valid expected %0d got %0d", want[33], rsp_tdata[33]);
               fail_count++;
            end
            if (rsp_tdata[65:34] !== want[65:34]) begin
               $error("write_value expected %h got %h", want[65:34], rsp_tdata[65:34]);
               fail_count++;
            end
            if (rsp_tdata[68:66] !== want[68:66]) begin
               $error("error_code expected %0d got %0d", want[68:66], rsp_tdata[68:66]);
               fail_count++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         execute_instr(req_tdata[5:0], req_tdata[37:6], req_tdata[69:38], prediction);
         result_queue.insert(result_queue.size(), prediction);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || word_taken) begin
         if (instr_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_tdata <= instr_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   initial begin
      int idle_modes[4][2];
      idle_modes = '{'{0, 0}, '{60, 0}, '{0, 60}, '{9, 9}};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      fail_count = 0;
      cycle_count = 0;
      send_idle = 0;
      recv_stall = 0;
      gen_depth = 0;
      hold_left = 0;
      hold_armed = 0;
      hold_taken = 0;
      word_taken = 0;
      depth_now = 0;
      foreach (var_set[i]) var_set[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      add_instr(OP_POP);
      add_instr(6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_instr(6'd63);
      add_instr(OP_LIT, 32'h7FFF_FFFF);
      add_instr(OP_LIT, 32'h8000_0000);
      add_instr(OP_ADD);
      add_instr(OP_LIT, 32'h8000_0000);
      add_instr(OP_LIT, 32'hFFFF_FFFF);
      add_instr(OP_DIV);
      add_instr(OP_LIT, 32'd0);
      add_instr(OP_DIV);
      add_instr(OP_SUB);
      add_instr(OP_WRITE);
      add_instr(OP_LOAD, 32'd3);
      add_instr(OP_ADDR, 32'd3);
      add_instr(OP_TRUE, 32'h1234_5678);
      add_instr(OP_ASSIGN);
      add_instr(OP_ADDR, 32'h8000_0000);
      add_instr(OP_READ, 32'd0, 32'hDEAD_BEEF);
      add_instr(OP_ADDR, 32'd4);
      add_instr(OP_READ, 32'd0, 32'h8000_0001);
      add_instr(OP_LOAD, 32'd4);
      add_instr(OP_LOAD, 32'd3);
      add_instr(OP_MUL);
      add_instr(OP_DUP);
      add_instr(OP_EQ);
      add_instr(OP_NOT);
      add_instr(OP_LABEL, 32'd77);
      add_instr(OP_JMPF);
      add_instr(OP_FALSE);
      add_instr(OP_LABEL, 32'hFFFF_FFFF);
      add_instr(OP_JMPF);
      add_instr(OP_LABEL, 32'd5);
      add_instr(OP_JMP);
      wait_drained();

      foreach (idle_modes[m]) begin
         send_idle = idle_modes[m][0];
         recv_stall = idle_modes[m][1];
         random_items(75);
         if (m == 0) begin
            @(posedge clock);
            hold_armed = 1;
         end
         random_items(75);
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0 && result_queue.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
